// ===== hdl/pge_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pge_pkg: shared types and constants of the polygon geometry engine
// Transfer payloads, command codes between front and back, register map.
// ----------------------------------------------------------------------------
package pge_pkg;

    localparam int MAX_VERTICES_DEF = 128;
    localparam int APB_AW           = 4;
    localparam int SQRT_STAGES      = 25;

    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_SCALE = 3'd1;
    localparam logic [2:0] ACT_QUERY = 3'd2;
    localparam logic [2:0] ACT_AREA  = 3'd3;
    localparam logic [2:0] ACT_PERIM = 3'd4;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_VCOUNT   = 2'd2;

    localparam logic [63:0] AREA_LIMIT  = 64'h01FF_FFFF_FFFF_FFFF;
    localparam logic [35:0] PERIM_LIMIT = 36'h1_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]         action;
        logic [6:0]         vertex_index;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [15:0]        scale_factor;
    } in_item_t;

    typedef struct packed {
        logic        inside_res;
        logic [56:0] area;
        logic [32:0] perimeter;
        logic        error;
    } out_item_t;

    typedef enum logic [5:0] {
        OP_LOAD  = 6'b000001,
        OP_SCALE = 6'b000010,
        OP_QUERY = 6'b000100,
        OP_AREA  = 6'b001000,
        OP_PERIM = 6'b010000,
        OP_NONE  = 6'b100000
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [6:0]         idx;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [15:0]        fac;
    } cmd_t;

    typedef struct packed {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [7:0]         vertex_count;
    } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/polygon_geometry_engine_core.sv =====
`default_nettype none
// Load and unknown actions register their result straight from the idle state.
// Scale, query, area and perimeter first walk the n vertices in use and then pass the drain state.
// One item is worked at a time; the edge walk reads one vertex per cycle from a
// single memory port, and the square-root pipeline sets the length of the drain.
// Reset clears the configuration registers and the queue and drops the result valid; the vertex memory is not cleared.
// ----------------------------------------------------------------------------
// polygon_geometry_engine_core: polygon geometry engine top level
// Configuration registers, front queue and back execution unit.
// ----------------------------------------------------------------------------
module polygon_geometry_engine_core #(
    parameter int MAX_VERTICES = pge_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire pge_pkg::in_item_t          in_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output pge_pkg::out_item_t              out_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pge_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import pge_pkg::*;

    cfg_t cfg_reg;
    logic cfg_wr;
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_CENTER_X: cfg_reg.cx           <= pwdata[23:0];
                REG_CENTER_Y: cfg_reg.cy           <= pwdata[23:0];
                REG_VCOUNT:   cfg_reg.vertex_count <= pwdata[7:0];
                default:      cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CENTER_X: prdata = {8'd0, cfg_reg.cx};
            REG_CENTER_Y: prdata = {8'd0, cfg_reg.cy};
            REG_VCOUNT:   prdata = {24'd0, cfg_reg.vertex_count};
            default:      prdata = '0;
        endcase
    end

    pge_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    pge_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ===== hdl/pge_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pge_front: input side
// Accepts items, decodes the action into a command and queues two deep.
// ----------------------------------------------------------------------------
module pge_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire pge_pkg::in_item_t in_data,
    output logic                  cmd_valid,
    output pge_pkg::cmd_t         cmd,
    input  wire logic             cmd_pop
);
    import pge_pkg::*;

    cmd_t       q_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    cmd_t       decoded;

    always_comb
    begin
        decoded.idx = in_data.vertex_index;
        decoded.px  = in_data.pos_x;
        decoded.py  = in_data.pos_y;
        decoded.fac = in_data.scale_factor;
        case (in_data.action)
            ACT_LOAD:  decoded.op = OP_LOAD;
            ACT_SCALE: decoded.op = OP_SCALE;
            ACT_QUERY: decoded.op = OP_QUERY;
            ACT_AREA:  decoded.op = OP_AREA;
            ACT_PERIM: decoded.op = OP_PERIM;
            default:   decoded.op = OP_NONE;
        endcase
    end

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pge_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pge_back: execution side
// Vertex memory, edge walk sequencer, cross-multiply, shoelace and
// pipelined square-root datapaths, result register.
// ----------------------------------------------------------------------------
module pge_back #(
    parameter int MAX_VERTICES = pge_pkg::MAX_VERTICES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pge_pkg::cfg_t      cfg,
    input  wire logic               cmd_valid,
    input  wire pge_pkg::cmd_t      cmd,
    output logic                    cmd_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output pge_pkg::out_item_t      out_data
);
    import pge_pkg::*;

    localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int CW    = (NW > 8) ? NW : 8;
    localparam int DRAIN = SQRT_STAGES + 7;
    localparam int DW    = $clog2(DRAIN + 1);
    localparam int SQW   = 51;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_SCALE = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    function automatic logic [23:0] sat24(input logic signed [32:0] q);
        logic [23:0] r;
        if (q > 33'sd8388607)
        begin
            r = 24'h7F_FFFF;
        end
        else if (q < -33'sd8388608)
        begin
            r = 24'h80_0000;
        end
        else
        begin
            r = q[23:0];
        end
        return r;
    endfunction

    state_t             state_reg, state_next;
    logic [NW-1:0]      s_reg, s_next;
    logic [DW-1:0]      drain_reg, drain_next;
    op_t                op_reg, op_next;
    logic signed [23:0] px_reg, px_next;
    logic signed [23:0] py_reg, py_next;
    logic [15:0]        fac_reg, fac_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    logic [CW-1:0]      cnt_ext, n_full, idx_ext;
    logic [NW-1:0]      n;
    logic               load_ok, load_we, rd_en, rd_first, clear_acc;
    logic [AW-1:0]      raddr, idx_addr;

    logic [23:0]        mem_x [0:MAX_VERTICES-1];
    logic [23:0]        mem_y [0:MAX_VERTICES-1];
    logic [23:0]        rdx_reg, rdy_reg;
    logic [AW-1:0]      a1_reg, wa_reg;
    logic               v1_reg, first1_reg, e2_reg, e3_reg, sw_reg;
    logic signed [40:0] psx_reg, psy_reg;
    logic signed [24:0] cur_x_reg, cur_y_reg, prev_x_reg, prev_y_reg;
    logic signed [25:0] a0, b0, a1, b1, dxe, dye, pxe, pye;
    logic signed [51:0] m0_reg, m1_reg;
    logic               cross_reg, dpos_reg, hit;
    logic               parity_reg;
    logic signed [63:0] sum_reg;
    logic [35:0]        perim_reg;
    logic [63:0]        mag, half;

    logic [SQW-1:0]     rem_reg  [0:SQRT_STAGES];
    logic [SQW-1:0]     root_reg [0:SQRT_STAGES];
    logic [SQRT_STAGES:0] sqv_reg;

    assign cnt_ext  = CW'(cfg.vertex_count);
    assign n_full   = (cnt_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : cnt_ext;
    assign n        = n_full[NW-1:0];
    assign idx_ext  = CW'(cmd.idx);
    assign load_ok  = (idx_ext < n_full);
    assign idx_addr = idx_ext[AW-1:0];

    assign mag  = (sum_reg < 64'sd0) ? 64'(-sum_reg) : 64'(sum_reg);
    assign half = mag >> 1;

    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        drain_next     = drain_reg;
        op_next        = op_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        fac_next       = fac_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        cmd_pop        = 1'b0;
        load_we        = 1'b0;
        rd_en          = 1'b0;
        rd_first       = 1'b0;
        raddr          = '0;
        clear_acc      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    cmd_pop    = 1'b1;
                    op_next    = cmd.op;
                    px_next    = cmd.px;
                    py_next    = cmd.py;
                    fac_next   = cmd.fac;
                    s_next     = '0;
                    drain_next = DW'(DRAIN);
                    clear_acc  = 1'b1;
                    case (cmd.op)
                        OP_LOAD:
                        begin
                            load_we             = load_ok;
                            out_valid_next      = 1'b1;
                            out_data_next       = '0;
                            out_data_next.error = !load_ok;
                        end
                        OP_SCALE:
                        begin
                            state_next = (n == '0) ? ST_DRAIN : ST_SCALE;
                        end
                        OP_QUERY, OP_AREA, OP_PERIM:
                        begin
                            state_next = (n == '0) ? ST_DRAIN : ST_WALK;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // read the last vertex first so that each later read closes an edge
                rd_en    = 1'b1;
                rd_first = (s_reg == '0);
                raddr    = (s_reg == '0) ? AW'(n - NW'(1)) : AW'(s_reg - NW'(1));
                s_next   = s_reg + NW'(1);
                if (s_reg == n)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_SCALE:
            begin
                rd_en  = 1'b1;
                raddr  = AW'(s_reg);
                s_next = s_reg + NW'(1);
                if (s_reg == n - NW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg - DW'(1);
                if (drain_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    case (op_reg)
                        OP_QUERY: out_data_next.inside_res = parity_reg;
                        OP_AREA:
                        begin
                            out_data_next.area = (half > AREA_LIMIT) ? AREA_LIMIT[56:0]
                                                                     : half[56:0];
                        end
                        OP_PERIM:
                        begin
                            out_data_next.perimeter = (perim_reg > PERIM_LIMIT)
                                                      ? PERIM_LIMIT[32:0] : perim_reg[32:0];
                        end
                        default: out_data_next = '0;
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s_reg         <= '0;
            drain_reg     <= '0;
            op_reg        <= OP_NONE;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            first1_reg    <= 1'b0;
            e2_reg        <= 1'b0;
            e3_reg        <= 1'b0;
            sw_reg        <= 1'b0;
            parity_reg    <= 1'b0;
            sum_reg       <= '0;
            perim_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            s_reg         <= s_next;
            drain_reg     <= drain_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
            v1_reg        <= rd_en;
            first1_reg    <= rd_first;
            e2_reg        <= v1_reg && !first1_reg && (op_reg != OP_SCALE);
            e3_reg        <= e2_reg;
            sw_reg        <= v1_reg && (op_reg == OP_SCALE);
            if (clear_acc)
            begin
                parity_reg <= 1'b0;
                sum_reg    <= '0;
                perim_reg  <= '0;
            end
            else
            begin
                if (e3_reg && cross_reg && hit)
                begin
                    parity_reg <= !parity_reg;
                end
                if (e3_reg)
                begin
                    sum_reg <= sum_reg + 64'(m0_reg);
                end
                if (sqv_reg[SQRT_STAGES])
                begin
                    perim_reg <= perim_reg + 36'(root_reg[SQRT_STAGES]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        fac_reg      <= fac_next;
        out_data_reg <= out_data_next;
    end

    // single write port: a load in idle, or a scaled vertex written back
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem_x[idx_addr] <= cmd.px;
            mem_y[idx_addr] <= cmd.py;
        end
        else if (sw_reg)
        begin
            mem_x[wa_reg] <= sat24(33'(psx_reg >>> 8));
            mem_y[wa_reg] <= sat24(33'(psy_reg >>> 8));
        end
        rdx_reg <= mem_x[raddr];
        rdy_reg <= mem_y[raddr];
    end

    // scale: multiply, then floor by arithmetic shift and saturate on write
    always_ff @(posedge clk)
    begin
        a1_reg  <= raddr;
        wa_reg  <= a1_reg;
        psx_reg <= 41'($signed(rdx_reg)) * 41'($signed({1'b0, fac_reg}));
        psy_reg <= 41'($signed(rdy_reg)) * 41'($signed({1'b0, fac_reg}));
    end

    // absolute coordinates; hold the previous vertex to form the edge
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            cur_x_reg  <= 25'(cfg.cx) + 25'($signed(rdx_reg));
            cur_y_reg  <= 25'(cfg.cy) + 25'($signed(rdy_reg));
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
    end

    always_comb
    begin
        dxe = 26'(prev_x_reg) - 26'(cur_x_reg);
        dye = 26'(prev_y_reg) - 26'(cur_y_reg);
        pxe = 26'(px_reg);
        pye = 26'(py_reg);
        case (op_reg)
            OP_QUERY:
            begin
                a0 = dxe;
                b0 = pye - 26'(cur_y_reg);
                a1 = pxe - 26'(cur_x_reg);
                b1 = dye;
            end
            OP_AREA:
            begin
                a0 = 26'(prev_x_reg) + 26'(cur_x_reg);
                b0 = dye;
                a1 = '0;
                b1 = '0;
            end
            default:
            begin
                a0 = dxe;
                b0 = dxe;
                a1 = dye;
                b1 = dye;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        m0_reg    <= 52'(a0) * 52'(b0);
        m1_reg    <= 52'(a1) * 52'(b1);
        cross_reg <= (cur_y_reg > 25'(py_reg)) != (prev_y_reg > 25'(py_reg));
        dpos_reg  <= (dye > 26'sd0);
    end

    assign hit = dpos_reg ? (m1_reg < m0_reg) : (m1_reg > m0_reg);

    // integer square root, one result bit per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqv_reg <= '0;
        end
        else
        begin
            sqv_reg <= {sqv_reg[SQRT_STAGES-1:0], e3_reg && (op_reg == OP_PERIM)};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= SQW'(m0_reg[49:0]) + SQW'(m1_reg[49:0]);
        root_reg[0] <= '0;
    end

    for (genvar g = 0; g < SQRT_STAGES; g++)
    begin : g_sqrt
        localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQRT_STAGES - 1 - g));
        logic [SQW-1:0] trial;
        assign trial = root_reg[g] + BIT;
        always_ff @(posedge clk)
        begin
            if (rem_reg[g] >= trial)
            begin
                rem_reg[g+1]  <= rem_reg[g] - trial;
                root_reg[g+1] <= (root_reg[g] >> 1) + BIT;
            end
            else
            begin
                rem_reg[g+1]  <= rem_reg[g];
                root_reg[g+1] <= root_reg[g] >> 1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ===== hdl/pge_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pge_checker: port-level checks of the polygon geometry engine
// Result hold, reset, exclusive result fields, always-ready register port.
// ----------------------------------------------------------------------------
module pge_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire pge_pkg::out_item_t out_data,
    input wire logic               pready
);
    import pge_pkg::*;

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result transfer changed");

    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({out_data.inside_res, |out_data.area,
                                  |out_data.perimeter, out_data.error}) <= 1)
        else $error("more than one result field set");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("register port not ready");

endmodule

bind polygon_geometry_engine_core pge_checker u_pge_checker (.*);
`default_nettype wire
